// ----- rtl/gmp_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gmp_pkg: shared types and constants for the group mean projection core
// Action codes, storage widths and the saturation limits of the level store.
// ----------------------------------------------------------------------------
package gmp_pkg;

  typedef enum logic [1:0] {
    ACT_ACCUM = 2'd0,
    ACT_APPLY = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  localparam int unsigned SumW   = 64;
  localparam int unsigned TotW   = 48;
  localparam int unsigned QuotW  = 41;
  localparam int unsigned DivSteps = 80;

  localparam logic [TotW-1:0] TotalMax = {TotW{1'b1}};
  localparam logic [QuotW-1:0] MeanCap = {1'b1, {(QuotW-1){1'b0}}};
  localparam logic [31:0] UnitWeight = 32'h0001_0000;

  localparam int unsigned CfgWeighted   = 0;
  localparam int unsigned CfgComplement = 1;

  // Request from the control sequencer to the divider
  typedef struct packed {
    logic            start;
    logic [SumW-1:0] mag;
    logic [TotW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QuotW-1:0] quot;
  } div_rsp_t;

endpackage
`default_nettype wire

// ----- rtl/gmp_divider.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gmp_divider: radix-2 restoring divider for the level mean
// Computes (mag * 2^16) / den one quotient bit per cycle, capped at 2^40.
// ----------------------------------------------------------------------------
module gmp_divider (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  gmp_pkg::div_req_t   req_i,
  output gmp_pkg::div_rsp_t   rsp_o
);

  localparam int unsigned CntW = $clog2(gmp_pkg::DivSteps + 1);

  logic [gmp_pkg::SumW-1:0]  mag_q, mag_d;
  logic [gmp_pkg::TotW-1:0]  den_q, den_d;
  logic [gmp_pkg::TotW:0]    rem_q, rem_d;
  logic [gmp_pkg::QuotW-1:0] quot_q, quot_d;
  logic [CntW-1:0]           cnt_q, cnt_d;
  logic                      busy_q, busy_d;
  logic                      done_q, done_d;

  logic [gmp_pkg::TotW:0]    shifted;
  logic                      fits;
  logic                      below_cap;

  always_comb begin
    shifted   = {rem_q[gmp_pkg::TotW-1:0], mag_q[gmp_pkg::SumW-1]};
    fits      = shifted >= {1'b0, den_q};
    below_cap = quot_q < gmp_pkg::MeanCap;
    mag_d  = mag_q;
    den_d  = den_q;
    rem_d  = rem_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      mag_d  = req_i.mag;
      den_d  = req_i.den;
      rem_d  = '0;
      quot_d = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // shift one dividend bit in, subtract where it fits
      mag_d = {mag_q[gmp_pkg::SumW-2:0], 1'b0};
      rem_d = fits ? shifted - {1'b0, den_q} : shifted;
      if (below_cap) begin
        quot_d = {quot_q[gmp_pkg::QuotW-2:0], fits};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(gmp_pkg::DivSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    den_q  <= den_d;
    rem_q  <= rem_d;
    quot_q <= quot_d;
  end

  // hold quotient at the cap once reached
  assign rsp_o.done = done_q;
  assign rsp_o.quot = (quot_q > gmp_pkg::MeanCap) ? gmp_pkg::MeanCap : quot_q;

endmodule
`default_nettype wire

// ----- rtl/group_mean_projection_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// group_mean_projection_core: per-level weighted demeaning
// Input words carry an action, a sample, a source, a weight and a one-based
// level. Accumulate words add value*weight and weight to the level entry,
// clear words zero it, apply words emit one result word: value minus the
// level mean (or source minus value plus mean in complement mode).
// Channels use valid/stall; a word moves when valid is high and stall low.
// Level sums and totals live in one synchronous memory (registered read).
// Accumulate and clear read the entry, then modify and write it back.
// Apply uses the bit-serial divider (80 steps) for the mean; an empty or
// bad level skips the divider. One word is in flight at a time; a finished
// result sits in the output register while the next word is accepted, and
// a stalled result holds until taken.
// After reset a clearing pass sweeps the store one level per cycle over all
// LEVELS entries (1024 by default); no input word is accepted meanwhile.
// Configuration writes are taken at any time the write enable is high.
// ----------------------------------------------------------------------------
module group_mean_projection_core #(
  parameter int unsigned LEVELS = 1024
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_stall_o,
  input  wire  [1:0]        action_i,
  input  wire signed [31:0] sample_value_i,
  input  wire signed [31:0] source_value_i,
  input  wire  [31:0]       sample_weight_i,
  input  wire  [10:0]       level_index_i,
  output logic              out_valid_o,
  input  wire               out_stall_i,
  output logic signed [31:0] result_value_o,
  output logic              level_empty_o,
  output logic              saturated_o,
  input  wire               cfg_we_i,
  input  wire  [0:0]        cfg_index_i,
  input  wire  [0:0]        cfg_wdata_i
);

  localparam int unsigned AddrW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int unsigned EntW  = gmp_pkg::SumW + gmp_pkg::TotW;

  typedef enum logic [5:0] {
    ST_CLR  = 6'b000001,
    ST_IDLE = 6'b000010,
    ST_READ = 6'b000100,
    ST_DIV  = 6'b001000,
    ST_FIN  = 6'b010000,
    ST_OUT  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic weighted_q, complement_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weighted_q   <= 1'b0;
      complement_q <= 1'b0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == 1'(gmp_pkg::CfgWeighted)) begin
        weighted_q <= cfg_wdata_i[0];
      end else begin
        complement_q <= cfg_wdata_i[0];
      end
    end
  end

  // level store
  logic [EntW-1:0]  mem_q [LEVELS];
  logic [EntW-1:0]  rdata_q;
  logic             mem_we;
  logic [AddrW-1:0] mem_waddr, mem_raddr;
  logic [EntW-1:0]  mem_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[mem_raddr];
  end

  // held input word
  gmp_pkg::action_e    act_q;
  logic signed [31:0]  val_q, src_q;
  logic [31:0]         wgt_q;
  logic [AddrW-1:0]    idx_q;
  logic                ok_q;
  logic [AddrW:0]      clr_q, clr_d;

  logic in_ok;
  logic [10:0] lvl_m1;
  assign lvl_m1 = level_index_i - 11'd1;
  assign in_ok  = (level_index_i != 11'd0) && (32'(level_index_i) <= LEVELS);

  // held product and divider interface
  logic signed [63:0] prod_q;
  gmp_pkg::div_req_t  dreq;
  gmp_pkg::div_rsp_t  drsp;

  gmp_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dreq),
    .rsp_o  (drsp)
  );

  logic signed [63:0] r_sum;
  logic [47:0]        r_tot;
  assign r_sum = signed'(rdata_q[EntW-1 -: gmp_pkg::SumW]);
  assign r_tot = rdata_q[gmp_pkg::TotW-1:0];

  logic               neg_q, empty_q, ssat_q;
  logic [63:0]        mag;
  assign mag = r_sum[63] ? 64'(-r_sum) : 64'(r_sum);

  // accumulate arithmetic on the read entry
  logic signed [63:0] addend, sum_new;
  logic signed [64:0] sum_wide;
  logic [48:0]        tot_wide;
  logic [31:0]        eff_w;
  assign eff_w    = weighted_q ? wgt_q : gmp_pkg::UnitWeight;
  assign addend   = prod_q >>> 16;
  assign sum_wide = 65'(r_sum) + 65'(addend);
  assign sum_new  = (sum_wide[64] != sum_wide[63]) ?
                    (sum_wide[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}}) : sum_wide[63:0];
  assign tot_wide = 49'(r_tot) + 49'(eff_w);

  // result register
  logic signed [31:0] res_q;
  logic               res_empty_q, res_sat_q, ovalid_q;
  logic signed [41:0] mean_s;
  logic signed [43:0] res_w;
  always_comb begin
    mean_s = empty_q ? 42'sd0 :
             (neg_q ? -signed'({1'b0, drsp.quot}) : signed'({1'b0, drsp.quot}));
    if (complement_q) begin
      res_w = 44'(src_q) - 44'(val_q) + 44'(mean_s);
    end else begin
      res_w = 44'(val_q) - 44'(mean_s);
    end
  end

  logic take_in, fin_now;
  assign in_stall_o = (state_q != ST_IDLE);
  assign take_in    = in_valid_i && !in_stall_o;
  assign fin_now    = (state_q == ST_FIN) && (!ovalid_q || !out_stall_i);

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    mem_we    = 1'b0;
    mem_waddr = idx_q;
    mem_wdata = {sum_new, (tot_wide > 49'(gmp_pkg::TotalMax)) ?
                 gmp_pkg::TotalMax : tot_wide[47:0]};
    mem_raddr = lvl_m1[AddrW-1:0];
    dreq.start = 1'b0;
    dreq.mag   = mag;
    dreq.den   = r_tot;
    case (state_q)
      ST_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q[AddrW-1:0];
        mem_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == (AddrW+1)'(LEVELS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (take_in) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        // entry data now valid in rdata_q
        case (act_q)
          gmp_pkg::ACT_ACCUM: begin
            mem_we  = ok_q;
            state_d = ST_IDLE;
          end
          gmp_pkg::ACT_CLEAR: begin
            mem_we    = ok_q;
            mem_wdata = '0;
            state_d   = ST_IDLE;
          end
          gmp_pkg::ACT_APPLY: begin
            if (ok_q && r_tot != '0) begin
              dreq.start = 1'b1;
              state_d    = ST_DIV;
            end else begin
              state_d = ST_FIN;
            end
          end
          default: state_d = ST_IDLE;
        endcase
      end
      ST_DIV: begin
        if (drsp.done) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (fin_now) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLR;
      clr_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      if (fin_now) begin
        ovalid_q <= 1'b1;
      end else if (!out_stall_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  // capture word, product and apply flags
  always_ff @(posedge clk_i) begin
    if (take_in) begin
      act_q <= gmp_pkg::action_e'(action_i);
      val_q <= sample_value_i;
      src_q <= source_value_i;
      wgt_q <= sample_weight_i;
      idx_q <= lvl_m1[AddrW-1:0];
      ok_q  <= in_ok;
    end
    if (state_q == ST_READ) begin
      neg_q   <= r_sum[63];
      empty_q <= !(ok_q && r_tot != '0);
      ssat_q  <= ok_q && r_tot != '0 &&
                 (r_sum == {1'b0, {63{1'b1}}} || r_sum == {1'b1, 63'd0} ||
                  r_tot == gmp_pkg::TotalMax);
    end
    if (state_q == ST_IDLE) begin
      prod_q <= 64'(sample_value_i) * signed'({32'd0, weighted_q ? sample_weight_i :
                                               gmp_pkg::UnitWeight});
    end
    if (fin_now) begin
      res_empty_q <= empty_q;
      if (res_w > 44'sd2147483647) begin
        res_q     <= 32'sh7FFF_FFFF;
        res_sat_q <= 1'b1;
      end else if (res_w < -44'sd2147483648) begin
        res_q     <= 32'sh8000_0000;
        res_sat_q <= 1'b1;
      end else begin
        res_q     <= res_w[31:0];
        res_sat_q <= ssat_q;
      end
    end
  end

  assign out_valid_o    = ovalid_q;
  assign result_value_o = res_q;
  assign level_empty_o  = res_empty_q;
  assign saturated_o    = res_sat_q;

  // checks
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLR) |-> in_stall_o) else $error("input taken during clear pass");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(result_value_o)))
    else $error("stalled result changed");
  a_div_only_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drsp.done |-> (state_q == ST_DIV)) else $error("divider finished out of state");

endmodule
`default_nettype wire

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for group_mean_projection_core
// Drives accumulate, apply, clear and unused words through the valid/stall
// input channel, predicts every apply result with a per-level sum/total
// model of its own, and checks result words field by field in order.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int NumLevels  = 1024;
  localparam int IdleLimit  = 20000;
  localparam int DrainWait  = 120;
  localparam int PhaseItems = 285;

  typedef struct {
    gmp_pkg::action_e   act;
    logic signed [31:0] val;
    logic signed [31:0] src;
    logic [31:0]        wt;
    logic [10:0]        lvl;
  } word_t;

  typedef struct {
    logic signed [31:0] value;
    logic               empty;
    logic               sat;
  } proj_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         action = gmp_pkg::ACT_NONE;
  logic signed [31:0] sample_value = '0;
  logic signed [31:0] source_value = '0;
  logic [31:0]        sample_weight = '0;
  logic [10:0]        level_index = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] result_value;
  logic               level_empty;
  logic               saturated;
  logic               cfg_we = 1'b0;
  logic [0:0]         cfg_index = '0;
  logic [0:0]         cfg_wdata = '0;

  // Level store copy and mode bits
  longint      level_sums [NumLevels];
  logic [47:0] level_totals [NumLevels];
  logic        weighted_on = 1'b0;
  logic        complement_on = 1'b0;

  word_t pending_words [$];
  proj_t expected_projs [$];
  int    send_idle_pct = 0;
  int    recv_idle_pct = 0;
  int    errors = 0;
  int    quiet_cycles = 0;

  group_mean_projection_core dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .action_i       (action),
    .sample_value_i (sample_value),
    .source_value_i (source_value),
    .sample_weight_i(sample_weight),
    .level_index_i  (level_index),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .result_value_o (result_value),
    .level_empty_o  (level_empty),
    .saturated_o    (saturated),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_wdata_i    (cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    errors++;
    $display("mismatch: %s", msg);
  endtask

  // Update the level store for one accepted word; queue the apply result
  task automatic project_word(input word_t w);
    logic               lvl_ok;
    int                 idx;
    logic [31:0]        wt;
    longint             prod;
    logic signed [64:0] acc;
    logic [48:0]        tot;
    logic [63:0]        mag;
    logic [79:0]        quot;
    longint             mean;
    longint             res;
    proj_t              p;
    lvl_ok = (w.lvl >= 1) && (w.lvl <= NumLevels);
    idx = lvl_ok ? int'(w.lvl) - 1 : 0;
    case (w.act)
      gmp_pkg::ACT_ACCUM: begin
        if (lvl_ok) begin
          wt = weighted_on ? w.wt : gmp_pkg::UnitWeight;
          prod = longint'(w.val) * longint'({32'b0, wt});
          acc = 65'(signed'(level_sums[idx])) + 65'(signed'(prod >>> 16));
          if (acc > 65'sh0_7FFF_FFFF_FFFF_FFFF) level_sums[idx] = 64'h7FFF_FFFF_FFFF_FFFF;
          else if (acc < -65'sh0_8000_0000_0000_0000)
            level_sums[idx] = 64'h8000_0000_0000_0000;
          else level_sums[idx] = longint'(acc);
          tot = {1'b0, level_totals[idx]} + {17'b0, wt};
          level_totals[idx] = tot > {1'b0, gmp_pkg::TotalMax} ? gmp_pkg::TotalMax
                                                              : tot[47:0];
        end
      end
      gmp_pkg::ACT_CLEAR: begin
        if (lvl_ok) begin
          level_sums[idx] = 0;
          level_totals[idx] = '0;
        end
      end
      gmp_pkg::ACT_APPLY: begin
        mean = 0;
        p.empty = 1'b1;
        p.sat = 1'b0;
        if (lvl_ok && level_totals[idx] != 0) begin
          mag = level_sums[idx] < 0 ? 64'(-level_sums[idx]) : 64'(level_sums[idx]);
          quot = {mag, 16'b0} / {32'b0, level_totals[idx]};
          if (quot > 80'(gmp_pkg::MeanCap)) quot = 80'(gmp_pkg::MeanCap);
          mean = level_sums[idx] < 0 ? -longint'(quot) : longint'(quot);
          p.empty = 1'b0;
          if (level_sums[idx] == 64'h7FFF_FFFF_FFFF_FFFF
              || level_sums[idx] == 64'h8000_0000_0000_0000
              || level_totals[idx] == gmp_pkg::TotalMax) p.sat = 1'b1;
        end
        res = complement_on ? longint'(w.src) - longint'(w.val) + mean
                            : longint'(w.val) - mean;
        if (res > 64'sh7FFF_FFFF) begin
          res = 64'sh7FFF_FFFF;
          p.sat = 1'b1;
        end else if (res < -64'sh8000_0000) begin
          res = -64'sh8000_0000;
          p.sat = 1'b1;
        end
        p.value = res[31:0];
        expected_projs.push_back(p);
      end
      default: ;
    endcase
  endtask

  // Feed words from the pending queue, idling at random
  always @(posedge clk) begin
    if (rst_n) begin
      if (!in_valid || !in_stall) begin
        if (in_valid) begin
          project_word('{gmp_pkg::action_e'(action), sample_value, source_value,
                         sample_weight, level_index});
        end
        if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          word_t w;
          w = pending_words.pop_front();
          in_valid      <= 1'b1;
          action        <= w.act;
          sample_value  <= w.val;
          source_value  <= w.src;
          sample_weight <= w.wt;
          level_index   <= w.lvl;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Check result words against the oldest projection; stall at random
  always @(posedge clk) begin
    if (rst_n) begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
      if (out_valid && !out_stall) begin
        proj_t p;
        if (expected_projs.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h", result_value));
        end else begin
          p = expected_projs.pop_front();
          if (result_value !== p.value)
            report_mismatch($sformatf("result_value %h, want %h", result_value, p.value));
          if (level_empty !== p.empty)
            report_mismatch($sformatf("level_empty %b, want %b", level_empty, p.empty));
          if (saturated !== p.sat)
            report_mismatch($sformatf("saturated %b, want %b", saturated, p.sat));
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IdleLimit) begin
        $display("** group_mean_projection_core: FAILED **");
        $finish;
      end
    end
  end

  task automatic push_word(input gmp_pkg::action_e act, input logic [31:0] val,
                           input logic [31:0] src, input logic [31:0] wt,
                           input logic [10:0] lvl);
    pending_words.push_back('{act, val, src, wt, lvl});
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($urandom_range(32'h0010_0000)) - 32'h0008_0000;
      2: case ($urandom_range(3))
           0: return 32'h7FFF_FFFF;
           1: return 32'h8000_0000;
           2: return 32'h0;
           default: return 32'hFFFF_FFFF;
         endcase
      default: return $urandom_range(32'h00FF_FFFF);
    endcase
  endfunction

  function automatic logic [31:0] pick_weight();
    case ($urandom_range(4))
      0: return $urandom;
      1: return $urandom_range(32'h0004_0000);
      2: return 32'h0;
      3: return 32'hFFFF_FFFF;
      default: return gmp_pkg::UnitWeight;
    endcase
  endfunction

  function automatic logic [10:0] pick_level();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 11'($urandom_range(1, 6));
    if (r < 85) return 11'($urandom_range(1, NumLevels));
    if (r < 90) return 11'(NumLevels);
    return 11'($urandom_range(2047));
  endfunction

  task automatic push_random(input int count);
    int r;
    gmp_pkg::action_e act;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      act = r < 45 ? gmp_pkg::ACT_ACCUM : r < 80 ? gmp_pkg::ACT_APPLY :
            r < 92 ? gmp_pkg::ACT_CLEAR : gmp_pkg::ACT_NONE;
      push_word(act, pick_value(), pick_value(), pick_weight(), pick_level());
    end
  endtask

  task automatic write_cfg(input int idx, input logic val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= 1'(idx);
    cfg_wdata <= val;
    if (idx == gmp_pkg::CfgWeighted) weighted_on = val;
    else complement_on = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Hold the sender until every queued word is taken and all results are in
  task automatic drain();
    while (pending_words.size() > 0 || in_valid || expected_projs.size() > 0)
      @(posedge clk);
    repeat (DrainWait) @(posedge clk);
  endtask

  initial begin
    for (int i = 0; i < NumLevels; i++) begin
      level_sums[i] = 0;
      level_totals[i] = '0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words: empty and bad levels, extremes, clipping, clear
    write_cfg(gmp_pkg::CfgWeighted, 1'b1);
    write_cfg(gmp_pkg::CfgComplement, 1'b1);
    push_word(gmp_pkg::ACT_APPLY, 32'h0001_0000, 32'h0002_0000, 32'h0, 11'd1);
    push_word(gmp_pkg::ACT_APPLY, 32'h1234_5678, 32'h0, 32'h0, 11'd0);
    push_word(gmp_pkg::ACT_APPLY, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 11'd2047);
    push_word(gmp_pkg::ACT_APPLY, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 11'd1025);
    push_word(gmp_pkg::ACT_ACCUM, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 11'd1);
    push_word(gmp_pkg::ACT_ACCUM, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 11'd1);
    push_word(gmp_pkg::ACT_APPLY, 32'h0, 32'hFFFF_FFFF, 32'h0, 11'd1);
    push_word(gmp_pkg::ACT_ACCUM, 32'hFFFF_FFFF, 32'h0, 32'h0000_0001, 11'd2);
    push_word(gmp_pkg::ACT_APPLY, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 11'd2);
    push_word(gmp_pkg::ACT_ACCUM, 32'h0003_0000, 32'h0, 32'h0, 11'd3);
    push_word(gmp_pkg::ACT_APPLY, 32'h0001_0000, 32'h0, 32'h0, 11'd3);
    push_word(gmp_pkg::ACT_ACCUM, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 11'd1024);
    push_word(gmp_pkg::ACT_APPLY, 32'h7FFF_FFFF, 32'h0, 32'h0, 11'd1024);
    push_word(gmp_pkg::ACT_CLEAR, 32'h0, 32'h0, 32'h0, 11'd1024);
    push_word(gmp_pkg::ACT_APPLY, 32'h7FFF_FFFF, 32'h0, 32'h0, 11'd1024);
    push_word(gmp_pkg::ACT_ACCUM, 32'h0005_0000, 32'h0, 32'h0001_0000, 11'd0);
    push_word(gmp_pkg::ACT_ACCUM, 32'h0005_0000, 32'h0, 32'h0001_0000, 11'd1025);
    push_word(gmp_pkg::ACT_CLEAR, 32'h0, 32'h0, 32'h0, 11'd2047);
    push_word(gmp_pkg::ACT_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 11'd1);
    push_word(gmp_pkg::ACT_APPLY, 32'h0, 32'h0, 32'h0, 11'd1);
    drain();
    write_cfg(gmp_pkg::CfgComplement, 1'b0);
    push_word(gmp_pkg::ACT_APPLY, 32'h8000_0000, 32'h0, 32'h0, 11'd1);
    push_word(gmp_pkg::ACT_APPLY, 32'h7FFF_FFFF, 32'h0, 32'h0, 11'd2);
    drain();

    // Random phases over all mode settings and idling patterns
    for (int ph = 0; ph < 6; ph++) begin
      write_cfg(gmp_pkg::CfgWeighted, ph[0]);
      write_cfg(gmp_pkg::CfgComplement, ph[1] ^ ph[2]);
      send_idle_pct = ph < 2 ? 32 : ph < 4 ? 75 : 0;
      recv_idle_pct = ph < 2 ? 75 : ph < 4 ? 32 : 0;
      push_random(PhaseItems);
      drain();
    end

    if (errors == 0) begin
      $display("** group_mean_projection_core: PASSED **");
    end else begin
      $display("** group_mean_projection_core: FAILED **");
    end
    $finish;
  end

endmodule
